// ===== rtl/hrcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrcd_pkg
// Shared types, fixed header texts and byte codes for the HTTP/1.1 response
// parser and chunked body decoder.
// ----------------------------------------------------------------------------
package hrcd_pkg;

   // default depth of the field window (bytes examined per field, plus one)
   localparam int HRCD_FIELD_BUF_LEN = 32;

   // byte codes
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   // encoding codes
   localparam logic [1:0] ENC_IDENTITY    = 2'd0;
   localparam logic [1:0] ENC_CHUNKED     = 2'd1;
   localparam logic [1:0] ENC_UNSUPPORTED = 2'd2;
   localparam logic [1:0] ENC_FINISHED    = 2'd3;

   // error flag bit positions
   localparam int ERR_VERSION = 0;
   localparam int ERR_STATUS  = 1;
   localparam int ERR_NUMBER  = 2;
   localparam int ERR_BYTE    = 3;

   // fixed texts, first character in the top byte
   localparam int VER_LEN = 8;
   localparam int CL_LEN  = 14;
   localparam int TE_LEN  = 17;
   localparam int CHK_LEN = 7;
   localparam int IDN_LEN = 8;

   localparam logic [8*VER_LEN-1:0] VER_TXT = "HTTP/1.1";
   localparam logic [8*CL_LEN-1:0]  CL_TXT  = "Content-Length";
   localparam logic [8*TE_LEN-1:0]  TE_TXT  = "Transfer-Encoding";
   localparam logic [8*CHK_LEN-1:0] CHK_TXT = "chunked";
   localparam logic [8*IDN_LEN-1:0] IDN_TXT = "identity";

   // one accepted input byte as held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] in_byte;
      logic       new_response;
   } hrcd_item_type;

endpackage

// ===== rtl/http_response_chunked_decoder_core.sv =====
// ----------------------------------------------------------------------------
// http_response_chunked_decoder_core
// HTTP/1.1 response parser with identity and chunked body decoding.
// ----------------------------------------------------------------------------
// Feed the response one byte per transfer on req_; set req_tuser on the first
// byte of a response to restart parsing. Every accepted byte yields exactly
// one result transfer on rsp_ carrying the decoded body byte (flagged by
// rsp_tuser) and the current status code, length, encoding and sticky error
// flags. The block sustains one byte per clock while rsp_ is not stalled:
// each byte is held in the input register and is parsed in a single pass
// into the result register, which offers it on rsp_. Input and output
// stalls are absorbed by those two registers without inserting bubbles.
module http_response_chunked_decoder_core #(
   parameter int FIELD_BUF_LEN = hrcd_pkg::HRCD_FIELD_BUF_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] new_response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] data_byte, [8] header_done,
                                    // [24:9] status_code, [25] length_known,
                                    // [57:26] body_length, [59:58] encoding,
                                    // [63:60] error_flags
   output logic        rsp_tuser    // [0] data_valid
);
   import hrcd_pkg::*;

   hrcd_item_type item;
   logic          take;

   hrcd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item       (item)
   );

   hrcd_parser #(
      .FIELD_BUF_LEN (FIELD_BUF_LEN)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/hrcd_in_stage.sv =====
// ----------------------------------------------------------------------------
// hrcd_in_stage
// Input register: captures one byte transfer and holds it until the parser
// takes it, while accepting the next transfer in the same cycle.
// ----------------------------------------------------------------------------
module hrcd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] in_byte
   input  logic                 req_tuser,   // [0] new_response
   input  logic                 take,
   output hrcd_pkg::hrcd_item_type item
);
   import hrcd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       new_ff;

   // free when empty or when the held byte leaves this cycle
   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   // hold valid under reset, payload without
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
         new_ff  <= req_tuser;
      end
   end

   assign item.valid        = valid_ff;
   assign item.in_byte      = byte_ff;
   assign item.new_response = new_ff;

endmodule

// ===== rtl/hrcd_parser.sv =====
// ----------------------------------------------------------------------------
// hrcd_parser
// Response parser state machine: updates the parse state for one byte per cycle
// unless rsp_ stalls, and writes the result register that drives the result channel.
// ----------------------------------------------------------------------------
module hrcd_parser #(
   parameter int FIELD_BUF_LEN = hrcd_pkg::HRCD_FIELD_BUF_LEN
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hrcd_pkg::hrcd_item_type item,
   output logic                    take,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,
   output logic                    rsp_tuser
);
   import hrcd_pkg::*;

   localparam int               POS_W    = $clog2(FIELD_BUF_LEN);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FIELD_BUF_LEN - 1);

   typedef enum logic [4:0] {
      PH_VER, PH_SP1, PH_STATUS, PH_REASON, PH_NAME, PH_CL_SP, PH_CL_VAL,
      PH_CL_LF, PH_TE_SP, PH_TE_VAL, PH_TE_LF, PH_SKIP, PH_BODY_ID,
      PH_BODY_BAD, PH_CSIZE, PH_CEXT, PH_CDATA, PH_CDATA_END, PH_LAST_CR,
      PH_LAST_LF, PH_DONE
   } ph_type;

   // parse state
   ph_type           phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       alive_ff, alive_in;
   logic [31:0]      accum_ff, accum_in;
   logic [15:0]      status_ff, status_in;
   logic [31:0]      length_ff, length_in;
   logic             seen_ff, seen_in;
   logic [1:0]       coding_ff, coding_in;
   logic [31:0]      chunk_ff, chunk_in;
   logic [3:0]       error_ff, error_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             dv_ff, dv_in;
   logic [7:0]       db_ff, db_in;
   logic             hdone_ff, hdone_in;

   logic [7:0]       c;
   logic [POS_W-1:0] p;
   logic [4:0]       hexv;
   logic [32:0]      len_sum;

   // decimal shift-add, saturating at the given maximum
   function automatic logic [31:0] dec_step(input logic [31:0] acc, input logic [7:0] ch,
                                            input logic [31:0] max);
      logic [35:0] sum;
      sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, 4'(ch - 8'h30)};
      if (sum > {4'b0, max}) begin
         return max;
      end
      return sum[31:0];
   endfunction

   // {ok, value} of a hex digit
   function automatic logic [4:0] hex_val(input logic [7:0] ch);
      if (ch >= 8'h30 && ch <= 8'h39) begin
         return {1'b1, 4'(ch - 8'h30)};
      end
      if (ch >= 8'h61 && ch <= 8'h66) begin
         return {1'b1, 4'(ch - 8'h57)};
      end
      if (ch >= 8'h41 && ch <= 8'h46) begin
         return {1'b1, 4'(ch - 8'h37)};
      end
      return 5'b0;
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= 8'h30 && ch <= 8'h39;
   endfunction

   // take the held byte whenever the result register can be written
   assign take = item.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      c         = item.in_byte;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      alive_in  = alive_ff;
      accum_in  = accum_ff;
      status_in = status_ff;
      length_in = length_ff;
      seen_in   = seen_ff;
      coding_in = coding_ff;
      chunk_in  = chunk_ff;
      error_in  = error_ff;
      dv_in     = 1'b0;
      db_in     = 8'h00;
      p         = pos_ff;
      hexv      = hex_val(c);
      len_sum   = {1'b0, length_ff} + {1'b0, accum_ff};

      // restart at the status line
      if (item.new_response) begin
         phase_in  = PH_VER;
         pos_in    = '0;
         alive_in  = 4'hF;
         accum_in  = '0;
         status_in = '0;
         length_in = '0;
         seen_in   = 1'b0;
         coding_in = ENC_IDENTITY;
         chunk_in  = '0;
         error_in  = '0;
         len_sum   = 33'd0;
      end

      unique case (phase_in)
         PH_VER: begin
            if (pos_in < POS_W'(VER_LEN) &&
                c != VER_TXT[8*(VER_LEN-1-int'(pos_in[2:0])) +: 8]) begin
               error_in[ERR_VERSION] = 1'b1;
            end
            pos_in = pos_in + 1'b1;
            if (pos_in >= POS_W'(VER_LEN)) begin
               phase_in = PH_SP1;
            end
         end
         PH_SP1: begin
            if (c != CH_SP) error_in[ERR_BYTE] = 1'b1;
            pos_in   = '0;
            alive_in = 4'hF;
            accum_in = '0;
            phase_in = PH_STATUS;
         end
         PH_STATUS: begin
            if (c == CH_SP || c == CH_LF) begin
               status_in = accum_in[15:0];
               if (c == CH_LF) begin
                  error_in[ERR_STATUS] = 1'b1;
                  pos_in   = '0;
                  alive_in = 4'hF;
                  accum_in = '0;
                  phase_in = PH_NAME;
               end else begin
                  phase_in = PH_REASON;
               end
            end else if (pos_in < POS_LAST) begin
               pos_in = pos_in + 1'b1;
               if (alive_in[0] && is_digit(c)) begin
                  accum_in = dec_step(accum_in, c, 32'h0000_FFFF);
               end else begin
                  alive_in[0]          = 1'b0;
                  error_in[ERR_STATUS] = 1'b1;
               end
            end
         end
         PH_REASON, PH_SKIP: begin
            if (c == CH_LF) begin
               pos_in   = '0;
               alive_in = 4'hF;
               accum_in = '0;
               phase_in = PH_NAME;
            end
         end
         PH_NAME: begin
            if (c == CH_LF) begin
               if (coding_in == ENC_CHUNKED) begin
                  pos_in   = '0;
                  alive_in = 4'hF;
                  accum_in = '0;
                  phase_in = PH_CSIZE;
               end else if (coding_in == ENC_IDENTITY) begin
                  phase_in = PH_BODY_ID;
               end else begin
                  phase_in = PH_BODY_BAD;
               end
            end else if (c == CH_COLON) begin
               if (alive_in[0] && pos_in == POS_W'(CL_LEN)) begin
                  phase_in = PH_CL_SP;
               end else if (alive_in[1] && pos_in == POS_W'(TE_LEN)) begin
                  phase_in = PH_TE_SP;
               end else begin
                  phase_in = PH_SKIP;
               end
            end else if (pos_in < POS_LAST) begin
               p      = pos_in;
               pos_in = pos_in + 1'b1;
               if (p >= POS_W'(CL_LEN) || c != CL_TXT[8*(CL_LEN-1-int'(p[3:0])) +: 8]) begin
                  alive_in[0] = 1'b0;
               end
               if (p >= POS_W'(TE_LEN) || c != TE_TXT[8*(TE_LEN-1-int'(p[4:0])) +: 8]) begin
                  alive_in[1] = 1'b0;
               end
            end
         end
         PH_CL_SP, PH_TE_SP: begin
            if (c != CH_SP) error_in[ERR_BYTE] = 1'b1;
            pos_in   = '0;
            alive_in = 4'hF;
            accum_in = '0;
            phase_in = (phase_in == PH_CL_SP) ? PH_CL_VAL : PH_TE_VAL;
         end
         PH_CL_VAL: begin
            if (c == CH_CR) begin
               length_in = accum_in;
               seen_in   = 1'b1;
               phase_in  = PH_CL_LF;
            end else if (pos_in < POS_LAST) begin
               pos_in = pos_in + 1'b1;
               if (alive_in[0] && is_digit(c)) begin
                  accum_in = dec_step(accum_in, c, 32'hFFFF_FFFF);
               end else begin
                  alive_in[0]          = 1'b0;
                  error_in[ERR_NUMBER] = 1'b1;
               end
            end
         end
         PH_TE_VAL: begin
            if (c == CH_CR) begin
               if (alive_in[2] && pos_in == POS_W'(CHK_LEN)) begin
                  coding_in = ENC_CHUNKED;
               end else if (!(alive_in[3] && pos_in == POS_W'(IDN_LEN))) begin
                  coding_in = ENC_UNSUPPORTED;
               end
               phase_in = PH_TE_LF;
            end else if (pos_in < POS_LAST) begin
               p      = pos_in;
               pos_in = pos_in + 1'b1;
               if (p >= POS_W'(CHK_LEN) ||
                   c != CHK_TXT[8*(CHK_LEN-1-int'(p[2:0])) +: 8]) begin
                  alive_in[2] = 1'b0;
               end
               if (p >= POS_W'(IDN_LEN) ||
                   c != IDN_TXT[8*(IDN_LEN-1-int'(p[2:0])) +: 8]) begin
                  alive_in[3] = 1'b0;
               end
            end
         end
         PH_CL_LF, PH_TE_LF: begin
            if (c != CH_LF) error_in[ERR_BYTE] = 1'b1;
            pos_in   = '0;
            alive_in = 4'hF;
            accum_in = '0;
            phase_in = PH_NAME;
         end
         PH_BODY_ID: begin
            dv_in = 1'b1;
            db_in = c;
         end
         PH_BODY_BAD: begin
         end
         PH_CSIZE: begin
            if (c == CH_SEMI || c == CH_CR) begin
               if (pos_in == '0) error_in[ERR_NUMBER] = 1'b1;
               chunk_in  = accum_in;
               length_in = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
               seen_in   = 1'b1;
               phase_in  = PH_CEXT;
            end else if (pos_in < POS_LAST) begin
               pos_in = pos_in + 1'b1;
               if (alive_in[0] && hexv[4]) begin
                  if (accum_in > 32'h0FFF_FFFF) begin
                     accum_in = 32'hFFFF_FFFF;
                  end else begin
                     accum_in = {accum_in[27:0], hexv[3:0]};
                  end
               end else begin
                  alive_in[0]          = 1'b0;
                  error_in[ERR_NUMBER] = 1'b1;
               end
            end
         end
         PH_CEXT: begin
            if (c == CH_LF) begin
               phase_in = (chunk_in == '0) ? PH_LAST_CR : PH_CDATA;
            end
         end
         PH_CDATA: begin
            dv_in    = 1'b1;
            db_in    = c;
            chunk_in = chunk_in - 1'b1;
            if (chunk_in == '0) phase_in = PH_CDATA_END;
         end
         PH_CDATA_END: begin
            if (c == CH_LF) begin
               pos_in   = '0;
               alive_in = 4'hF;
               accum_in = '0;
               phase_in = PH_CSIZE;
            end
         end
         PH_LAST_CR: begin
            if (c != CH_CR) error_in[ERR_BYTE] = 1'b1;
            phase_in = PH_LAST_LF;
         end
         PH_LAST_LF: begin
            if (c != CH_LF) error_in[ERR_BYTE] = 1'b1;
            coding_in = ENC_FINISHED;
            phase_in  = PH_DONE;
         end
         PH_DONE: begin
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      hdone_in = (phase_in >= PH_BODY_ID);
   end

   // drop the result once taken, refill on every parsed byte
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // hold parse state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_VER;
         pos_ff       <= '0;
         alive_ff     <= 4'hF;
         accum_ff     <= '0;
         status_ff    <= '0;
         length_ff    <= '0;
         seen_ff      <= 1'b0;
         coding_ff    <= ENC_IDENTITY;
         chunk_ff     <= '0;
         error_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            alive_ff  <= alive_in;
            accum_ff  <= accum_in;
            status_ff <= status_in;
            length_ff <= length_in;
            seen_ff   <= seen_in;
            coding_ff <= coding_in;
            chunk_ff  <= chunk_in;
            error_ff  <= error_in;
            dv_ff     <= dv_in;
            db_ff     <= db_in;
            hdone_ff  <= hdone_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = dv_ff;
   assign rsp_tdata  = {error_ff, coding_ff, length_ff, seen_ff, status_ff, hdone_ff, db_ff};

endmodule

// ===== rtl/hrcd_checker.sv =====
// ----------------------------------------------------------------------------
// hrcd_checker
// Port-level checks of the response parser, bound to the top level.
// ----------------------------------------------------------------------------
module hrcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);
   import hrcd_pkg::*;

   // a stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // body bytes only after the header
   a_body_after_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[8])
      else $error("body byte before header end");

   // no body byte means a zero data byte
   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'h00)
      else $error("data byte set without data flag");

   // finished body implies header done
   a_done_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[59:58] == ENC_FINISHED |-> rsp_tdata[8])
      else $error("finished without header end");

endmodule

bind http_response_chunked_decoder_core hrcd_checker u_hrcd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
